>>> hw/rtl/assert_macros.svh
// assertion macros for the rtl files, included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition must hold at every clock edge out of reset
`define U8IP_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define U8IP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`else

`define U8IP_ASSERT_ALWAYS(lbl, cond)
`define U8IP_ASSERT_IMPL(lbl, ante, cons)

`endif

`endif

>>> hw/rtl/u8ip_pkg.sv
// shared types, constants and helpers of the address-to-text block
`timescale 1ns / 1ps

package u8ip_pkg;

  // input decoding constants
  localparam logic [7:0] LEAD_C2    = 8'hC2;
  localparam logic [7:0] LEAD_C3    = 8'hC3;
  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] C3_OFFSET  = 8'h40;
  localparam logic [4:0] ADDR_BYTES = 5'd16;

  // mapped-address marker word (bytes ten and eleven)
  localparam logic [15:0] MAP_MARK = 16'hFFFF;

  // decimal weights for the subtract unit
  localparam logic [7:0] DEC_HUND = 8'd100;
  localparam logic [7:0] DEC_TEN  = 8'd10;

  // ascii characters
  localparam logic [6:0] CH_NUL   = 7'h00;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_LOW_A = 7'h61;
  localparam logic [6:0] CH_COLON = 7'h3A;
  localparam logic [6:0] CH_DOT   = 7'h2E;

  // store of sixteen bytes as eight big-endian words
  typedef logic [15:0]      word_t;
  typedef word_t [7:0]      words_t;

  // request from the collector to the formatter
  typedef struct packed {
    logic go;
    logic err;
  } fmt_ctl_t;

  // lower-case hex digit
  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] ch;
    if (nib < 4'd10) begin
      ch = CH_ZERO + 7'(nib);
    end else begin
      ch = CH_LOW_A + 7'(nib) - 7'd10;
    end
    return ch;
  endfunction

endpackage

>>> hw/rtl/u8ip_if.sv
// stream interfaces for raw bytes in and text characters out
`timescale 1ns / 1ps

interface u8ip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface u8ip_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       out_last;
  logic       out_error;

  modport source (output valid, output out_char, output out_last, output out_error,
                  input ready);
  modport sink   (input valid, input out_char, input out_last, input out_error,
                  output ready);
endinterface

>>> hw/rtl/u8ip_fmt.sv
// text formatter: hex groups, dotted decimal or an error marker, at most one character per step
`timescale 1ns / 1ps

module u8ip_fmt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  u8ip_pkg::fmt_ctl_t ctl_i,
  input  u8ip_pkg::words_t   words_i,
  output logic               done_o,
  u8ip_out_if.source         out_o
);
  import u8ip_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ERR, S_HEX, S_COLON, S_DEC_H, S_DEC_T, S_DEC_O, S_DOT
  } state_e;

  state_e     st_q, st_d;
  logic [2:0] grp_q, grp_d;
  logic [1:0] nib_q, nib_d;
  logic       lead_q, lead_d;
  logic [7:0] rem_q, rem_d;
  logic [3:0] dig_q, dig_d;
  logic       ovld_q, ovld_d;
  logic [6:0] ochar_q, ochar_d;
  logic       olast_q, olast_d;
  logic       oerr_q, oerr_d;

  logic       adv;
  logic       mapped;
  logic [1:0] oct_sel;
  logic [2:0] rd_idx;
  word_t      rd_word;
  logic [7:0] rd_byte;
  logic [3:0] nibble;
  logic [7:0] k_w;
  logic       ge;
  logic [7:0] diff;
  logic       emit;
  logic [6:0] e_char;
  logic       e_last;
  logic       e_err;

  // mapped form: ten zero bytes then two 0xff bytes
  assign mapped = (words_i[0] == '0) && (words_i[1] == '0) && (words_i[2] == '0) &&
                  (words_i[3] == '0) && (words_i[4] == '0) && (words_i[5] == MAP_MARK);

  // single read port into the store
  assign oct_sel = (st_q == S_DOT) ? (grp_q[1:0] + 2'd1) : 2'd0;
  assign rd_idx  = (st_q == S_HEX) ? grp_q : (3'd6 + {2'b00, oct_sel[1]});
  assign rd_word = words_i[rd_idx];
  assign rd_byte = oct_sel[0] ? rd_word[7:0] : rd_word[15:8];
  assign nibble  = rd_word[{nib_q, 2'b00} +: 4];

  // shared compare and subtract unit for decimal digits
  assign k_w  = (st_q == S_DEC_H) ? DEC_HUND : DEC_TEN;
  assign ge   = (rem_q >= k_w);
  assign diff = rem_q - k_w;

  assign adv = !ovld_q || out_o.ready;

  // sequencer
  always_comb begin
    st_d   = st_q;
    grp_d  = grp_q;
    nib_d  = nib_q;
    lead_d = lead_q;
    rem_d  = rem_q;
    dig_d  = dig_q;
    emit   = 1'b0;
    e_char = CH_NUL;
    e_last = 1'b0;
    e_err  = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (ctl_i.go) begin
          grp_d  = '0;
          nib_d  = 2'd3;
          lead_d = 1'b0;
          dig_d  = '0;
          rem_d  = rd_byte;
          if (ctl_i.err) begin
            st_d = S_ERR;
          end else if (mapped) begin
            st_d = S_DEC_H;
          end else begin
            st_d = S_HEX;
          end
        end
      end
      S_ERR: begin
        emit   = 1'b1;
        e_char = CH_NUL;
        e_last = 1'b1;
        e_err  = 1'b1;
        st_d   = S_IDLE;
      end
      S_HEX: begin
        if (nibble == 4'd0 && !lead_q && nib_q != 2'd0) begin
          nib_d = nib_q - 2'd1;
        end else begin
          emit   = 1'b1;
          e_char = hex_char(nibble);
          lead_d = 1'b1;
          if (nib_q == 2'd0) begin
            if (grp_q == 3'd7) begin
              e_last = 1'b1;
              st_d   = S_IDLE;
            end else begin
              st_d = S_COLON;
            end
          end else begin
            nib_d = nib_q - 2'd1;
          end
        end
      end
      S_COLON: begin
        emit   = 1'b1;
        e_char = CH_COLON;
        grp_d  = grp_q + 3'd1;
        nib_d  = 2'd3;
        lead_d = 1'b0;
        st_d   = S_HEX;
      end
      S_DEC_H: begin
        if (ge) begin
          rem_d = diff;
          dig_d = dig_q + 4'd1;
        end else begin
          if (dig_q != 4'd0) begin
            emit   = 1'b1;
            e_char = CH_ZERO + {3'b000, dig_q};
            lead_d = 1'b1;
          end
          dig_d = '0;
          st_d  = S_DEC_T;
        end
      end
      S_DEC_T: begin
        if (ge) begin
          rem_d = diff;
          dig_d = dig_q + 4'd1;
        end else begin
          if (dig_q != 4'd0 || lead_q) begin
            emit   = 1'b1;
            e_char = CH_ZERO + {3'b000, dig_q};
          end
          dig_d = '0;
          st_d  = S_DEC_O;
        end
      end
      S_DEC_O: begin
        emit   = 1'b1;
        e_char = CH_ZERO + {3'b000, rem_q[3:0]};
        if (grp_q[1:0] == 2'd3) begin
          e_last = 1'b1;
          st_d   = S_IDLE;
        end else begin
          st_d = S_DOT;
        end
      end
      S_DOT: begin
        emit   = 1'b1;
        e_char = CH_DOT;
        grp_d  = grp_q + 3'd1;
        rem_d  = rd_byte;
        dig_d  = '0;
        lead_d = 1'b0;
        st_d   = S_DEC_H;
      end
      default: st_d = S_IDLE;
    endcase

    // output register: a step runs only when the slot is free
    ovld_d  = ovld_q;
    ochar_d = ochar_q;
    olast_d = olast_q;
    oerr_d  = oerr_q;
    if (adv) begin
      ovld_d = emit;
      if (emit) begin
        ochar_d = e_char;
        olast_d = e_last;
        oerr_d  = e_err;
      end
    end else begin
      st_d   = st_q;
      grp_d  = grp_q;
      nib_d  = nib_q;
      lead_d = lead_q;
      rem_d  = rem_q;
      dig_d  = dig_q;
    end
  end

  assign done_o = adv && emit && e_last;

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      grp_q   <= '0;
      nib_q   <= '0;
      lead_q  <= 1'b0;
      dig_q   <= '0;
      ovld_q  <= 1'b0;
      rem_q   <= '0;
      ochar_q <= '0;
      olast_q <= 1'b0;
      oerr_q  <= 1'b0;
    end else begin
      st_q    <= st_d;
      grp_q   <= grp_d;
      nib_q   <= nib_d;
      lead_q  <= lead_d;
      dig_q   <= dig_d;
      ovld_q  <= ovld_d;
      rem_q   <= rem_d;
      ochar_q <= ochar_d;
      olast_q <= olast_d;
      oerr_q  <= oerr_d;
    end
  end

  assign out_o.valid     = ovld_q;
  assign out_o.out_char  = ochar_q;
  assign out_o.out_last  = olast_q;
  assign out_o.out_error = oerr_q;

endmodule

>>> hw/rtl/utf8_ip_bytes_to_text.sv
// top level: collects encoded address bytes and emits the address as text
//
//  port    direction  request                        accepted when
//  in_i    sink       in_byte, in_last               valid && ready
//  out_o   source     out_char, out_last, out_error  valid && ready
//
// Raw bytes are taken one per cycle while an address is being collected.
// After the last byte the formatter takes a start step, then for hex one
// step per nibble, skipped or not, and per colon; for dotted decimal, per
// octet, one step per subtraction and per digit place, plus one per dot; an
// error result takes one step. ready stays low until the last character is
// registered. Reset is asynchronous and clears the byte store, counters and flags.
// While the output register is full, a low ready on out_o freezes the formatter.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utf8_ip_bytes_to_text (
  input  logic       clk_i,
  input  logic       rst_ni,
  u8ip_in_if.sink    in_i,
  u8ip_out_if.source out_o
);
  import u8ip_pkg::*;

  typedef enum logic [1:0] {PEND_NONE, PEND_C2, PEND_C3} pend_e;

  words_t     words_q, words_d;
  logic [4:0] dcnt_q, dcnt_d;
  logic [4:0] raw_q, raw_d;
  pend_e      pend_q, pend_d;
  logic       err_q, err_d;
  logic       busy_q, busy_d;

  logic       acc;
  logic [4:0] raw_n;
  pend_e      pend_n;
  logic       err_n;
  logic       wr_en;
  logic [7:0] wr_val;
  logic [2:0] wr_w;
  words_t     words_n;
  logic [4:0] dcnt_n;

  fmt_ctl_t   ctl;
  logic       fmt_done;

  assign acc        = in_i.valid && in_i.ready;
  assign in_i.ready = !busy_q;

  // decode one raw byte and update the store
  always_comb begin
    pend_n  = pend_q;
    err_n   = err_q;
    wr_en   = 1'b0;
    wr_val  = '0;
    words_n = words_q;
    dcnt_n  = dcnt_q;
    wr_w    = dcnt_q[3:1];
    raw_n   = (raw_q < ADDR_BYTES) ? (raw_q + 5'd1) : raw_q;

    unique case (pend_q)
      PEND_C2: begin
        wr_en  = 1'b1;
        wr_val = in_i.in_byte;
        pend_n = PEND_NONE;
      end
      PEND_C3: begin
        wr_en  = 1'b1;
        wr_val = in_i.in_byte + C3_OFFSET;
        pend_n = PEND_NONE;
      end
      PEND_NONE: begin
        if (in_i.in_byte == LEAD_C3) begin
          pend_n = PEND_C3;
        end else if (in_i.in_byte == LEAD_C2) begin
          pend_n = PEND_C2;
        end else if (in_i.in_byte <= ASCII_MAX) begin
          wr_en  = 1'b1;
          wr_val = in_i.in_byte;
        end else begin
          err_n = 1'b1;
        end
      end
      default: pend_n = PEND_NONE;
    endcase

    // lead byte at the end pairs with a zero byte
    if (in_i.in_last) begin
      if (pend_n == PEND_C2) begin
        wr_en  = 1'b1;
        wr_val = '0;
      end else if (pend_n == PEND_C3) begin
        wr_en  = 1'b1;
        wr_val = C3_OFFSET;
      end
      pend_n = PEND_NONE;
      if (raw_n < ADDR_BYTES) begin
        err_n = 1'b1;
      end
    end

    // store, or flag overflow past sixteen bytes
    if (wr_en) begin
      if (dcnt_q[4]) begin
        err_n = 1'b1;
      end else begin
        if (dcnt_q[0]) begin
          words_n[wr_w][7:0] = wr_val;
        end else begin
          words_n[wr_w][15:8] = wr_val;
        end
        dcnt_n = dcnt_q + 5'd1;
      end
    end
  end

  // commit on accept, clear once the text is out
  always_comb begin
    words_d = words_q;
    dcnt_d  = dcnt_q;
    raw_d   = raw_q;
    pend_d  = pend_q;
    err_d   = err_q;
    busy_d  = busy_q;
    if (acc) begin
      words_d = words_n;
      dcnt_d  = dcnt_n;
      raw_d   = raw_n;
      pend_d  = pend_n;
      err_d   = err_n;
      busy_d  = in_i.in_last;
    end
    if (fmt_done) begin
      words_d = '0;
      dcnt_d  = '0;
      raw_d   = '0;
      pend_d  = PEND_NONE;
      err_d   = 1'b0;
      busy_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q <= '0;
      dcnt_q  <= '0;
      raw_q   <= '0;
      pend_q  <= PEND_NONE;
      err_q   <= 1'b0;
      busy_q  <= 1'b0;
    end else begin
      words_q <= words_d;
      dcnt_q  <= dcnt_d;
      raw_q   <= raw_d;
      pend_q  <= pend_d;
      err_q   <= err_d;
      busy_q  <= busy_d;
    end
  end

  // formatter
  assign ctl.go  = busy_q;
  assign ctl.err = err_q;

  u8ip_fmt u_fmt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .words_i (words_q),
    .done_o  (fmt_done),
    .out_o   (out_o)
  );

  // checks
  `U8IP_ASSERT_ALWAYS(a_dcnt_range, dcnt_q <= ADDR_BYTES)
  `U8IP_ASSERT_ALWAYS(a_raw_range, raw_q <= ADDR_BYTES)
  `U8IP_ASSERT_IMPL(a_done_busy, fmt_done, busy_q)
  `U8IP_ASSERT_IMPL(a_err_last, out_o.valid && out_o.out_error, out_o.out_last)
  `U8IP_ASSERT_IMPL(a_err_char, out_o.valid && out_o.out_error, out_o.out_char == CH_NUL)

endmodule
